/* sv/nsjf_pkg.sv */
// Shared types, constants and helpers for the shortest-job-first scheduler.
// Used by nsjf_cmp and nonpreemptive_sjf_scheduler; depends on nothing.
package nsjf_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int ID_BITS     = 8;
   localparam int TIME_BITS   = 16;

   localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
   localparam int SCAN_BITS   = $clog2(TABLE_DEPTH + 1);
   localparam int BURST_W     = 16;
   localparam int PORT_TIME_W = 16;

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic [1:0] STATUS_ACCEPTED   = 2'd0;
   localparam logic [1:0] STATUS_FULL       = 2'd1;
   localparam logic [1:0] STATUS_ZERO_BURST = 2'd2;
   localparam logic [1:0] STATUS_TICK       = 2'd3;

   typedef struct packed {
      logic [ID_BITS-1:0]   job;
      logic [TIME_BITS-1:0] arrival;
      logic [TIME_BITS-1:0] burst;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FREE,
      ST_SCAN,
      ST_DISPATCH,
      ST_EXEC,
      ST_FINISH,
      ST_RESP
   } state_type;

   // Clamp an arriving burst to the internal time range.
   function automatic logic [TIME_BITS-1:0] sat_burst(input logic [BURST_W-1:0] b);
      logic [31:0] w;
      w = 32'(b);
      if (w > 32'(TIME_MAX)) begin
         return TIME_MAX;
      end
      return TIME_BITS'(w);
   endfunction

   // Increment, holding at the largest value.
   function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] t);
      if (t == TIME_MAX) begin
         return t;
      end
      return t + 1'b1;
   endfunction

   // Bring an internal time value to the 16-bit result width.
   function automatic logic [PORT_TIME_W-1:0] to_port(input logic [TIME_BITS-1:0] t);
      logic [31:0] w;
      w = 32'(t);
      return w[PORT_TIME_W-1:0];
   endfunction

endpackage

/* sv/nonpreemptive_sjf_scheduler.sv */
// Non-preemptive shortest-job-first scheduler, top level.
// Depends on nsjf_pkg, nsjf_ram and nsjf_cmp.
//
// Usage:
//   Drive req_op, req_job_id and req_burst and raise start while busy is low;
//   the item is taken at that clock edge and busy stays high until its result
//   has been shown. req_op selects an arrival (job enters the ready table) or
//   a tick (one time unit passes on the CPU).
//   Every item yields exactly one result: rsp_valid is high for a single
//   cycle with all rsp_ fields, and the result is taken at the end of that
//   cycle. The receiver cannot stall, so nothing is ever held back.
// Sequencing, with D table slots:
//   zero-burst arrival: answered without touching the table.
//   arrival: walks the slots in order until it finds a free one or has
//   looked at all D; a full table is reported as such.
//   tick with a running job: runs it one unit, plus a finish step when it ends.
//   tick with the CPU idle: all D slots are scanned first to pick a job; the
//   ready table sits in a RAM with one read port and the shared comparator
//   looks at one slot per cycle.
//   A new item can be started the cycle after rsp_valid.
// Reset: synchronous, clears the ready table's valid bits, the tick counter
// and the CPU; slot contents are not cleared and need not be.
module nonpreemptive_sjf_scheduler
   import nsjf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_op,
   input  logic [ID_BITS-1:0]     req_job_id,
   input  logic [BURST_W-1:0]     req_burst,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [ID_BITS-1:0]     rsp_running_id,
   output logic                   rsp_dispatched,
   output logic                   rsp_finished,
   output logic [PORT_TIME_W-1:0] rsp_finish_time,
   output logic [PORT_TIME_W-1:0] rsp_wait_time
);

   // Sequencer state and the item being worked on.
   state_type              state_ff, state_in;
   logic                   op_ff, op_in;
   logic [ID_BITS-1:0]     job_ff, job_in;
   logic [TIME_BITS-1:0]   burst_ff, burst_in;
   logic [SCAN_BITS-1:0]   cnt_ff, cnt_in;

   // Ready table: valid bits in flops, slot contents in RAM.
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;

   // Scan pipeline: one slot read is in flight ahead of the compare.
   logic                   pend_ff, pend_in;
   logic [SLOT_BITS-1:0]   pend_idx_ff, pend_idx_in;
   slot_type               best_ff, best_in;
   logic [SLOT_BITS-1:0]   best_idx_ff, best_idx_in;
   logic                   best_found_ff, best_found_in;

   // CPU and clock.
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic                   cpu_busy_ff, cpu_busy_in;
   slot_type               cur_ff, cur_in;
   logic [TIME_BITS-1:0]   rem_ff, rem_in;
   logic [TIME_BITS-1:0]   fin_ff, fin_in;
   logic [TIME_BITS:0]     used_ff, used_in;

   // Result registers.
   logic [1:0]             status_ff, status_in;
   logic [ID_BITS-1:0]     run_id_ff, run_id_in;
   logic                   disp_ff, disp_in;
   logic                   done_ff, done_in;
   logic [PORT_TIME_W-1:0] fin_out_ff, fin_out_in;
   logic [PORT_TIME_W-1:0] wait_out_ff, wait_out_in;

   // Shared unit wiring.
   logic [SLOT_BITS-1:0]   idx;
   logic                   last_slot;
   logic                   scan_done;
   logic                   ram_we;
   slot_type               ram_wdata;
   logic [SLOT_W-1:0]      ram_rdata;
   slot_type               cand;
   logic                   cand_better;
   logic [TIME_BITS-1:0]   rem_dec;
   logic [TIME_BITS:0]     wait_diff;

   assign idx       = cnt_ff[SLOT_BITS-1:0];
   assign last_slot = cnt_ff == SCAN_BITS'(TABLE_DEPTH - 1);
   assign scan_done = cnt_ff == SCAN_BITS'(TABLE_DEPTH);
   assign rem_dec   = (rem_ff != '0) ? rem_ff - 1'b1 : rem_ff;
   assign wait_diff = {1'b0, fin_ff} - used_ff;

   // Write the arriving job into the first free slot the walk reaches.
   assign ram_we    = (state_ff == ST_FREE) && !valid_ff[idx];
   assign ram_wdata = '{job: job_ff, arrival: now_ff, burst: burst_ff};

   nsjf_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx),
      .wr_data (ram_wdata),
      .rd_addr (idx),
      .rd_data (ram_rdata)
   );

   assign cand = slot_type'(ram_rdata);

   nsjf_cmp u_cmp (
      .cand       (cand),
      .best       (best_ff),
      .best_found (best_found_ff),
      .better     (cand_better)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_op == OP_ARRIVE) begin
                  state_in = (req_burst == '0) ? ST_RESP : ST_FREE;
               end else begin
                  state_in = cpu_busy_ff ? ST_EXEC : ST_SCAN;
               end
            end
         end
         ST_FREE: begin
            if (!valid_ff[idx] || last_slot) begin
               state_in = ST_RESP;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = (cpu_busy_ff && rem_dec == '0) ? ST_FINISH : ST_RESP;
         end
         ST_FINISH: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and result updates per state.
   always_comb begin
      op_in         = op_ff;
      job_in        = job_ff;
      burst_in      = burst_ff;
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      best_found_in = best_found_ff;
      now_in        = now_ff;
      cpu_busy_in   = cpu_busy_ff;
      cur_in        = cur_ff;
      rem_in        = rem_ff;
      fin_in        = fin_ff;
      used_in       = used_ff;
      status_in     = status_ff;
      run_id_in     = run_id_ff;
      disp_in       = disp_ff;
      done_in       = done_ff;
      fin_out_in    = fin_out_ff;
      wait_out_in   = wait_out_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // Latch the item and clear the result fields.
               op_in         = req_op;
               job_in        = req_job_id;
               burst_in      = sat_burst(req_burst);
               cnt_in        = '0;
               best_found_in = 1'b0;
               run_id_in     = '0;
               disp_in       = 1'b0;
               done_in       = 1'b0;
               fin_out_in    = '0;
               wait_out_in   = '0;
               if (req_op == OP_TICK) begin
                  status_in = STATUS_TICK;
               end else if (req_burst == '0) begin
                  status_in = STATUS_ZERO_BURST;
               end else begin
                  status_in = STATUS_ACCEPTED;
               end
            end
         end
         ST_FREE: begin
            cnt_in = cnt_ff + 1'b1;
            if (!valid_ff[idx]) begin
               valid_in[idx] = 1'b1;
               status_in     = STATUS_ACCEPTED;
            end else if (last_slot) begin
               status_in = STATUS_FULL;
            end
         end
         ST_SCAN: begin
            // Issue the read for slot cnt, compare the slot read last cycle.
            cnt_in      = cnt_ff + 1'b1;
            pend_in     = !scan_done && valid_ff[idx];
            pend_idx_in = idx;
            if (pend_ff && cand_better) begin
               best_in       = cand;
               best_idx_in   = pend_idx_ff;
               best_found_in = 1'b1;
            end
         end
         ST_DISPATCH: begin
            if (best_found_ff) begin
               valid_in[best_idx_ff] = 1'b0;
               cur_in                = best_ff;
               rem_in                = best_ff.burst;
               cpu_busy_in           = 1'b1;
               disp_in               = 1'b1;
            end
         end
         ST_EXEC: begin
            // Run one unit, then advance the clock.
            if (cpu_busy_ff) begin
               rem_in    = rem_dec;
               run_id_in = cur_ff.job;
               if (rem_dec == '0) begin
                  done_in     = 1'b1;
                  fin_in      = sat_inc(now_ff);
                  used_in     = {1'b0, cur_ff.arrival} + {1'b0, cur_ff.burst};
                  cpu_busy_in = 1'b0;
               end
            end
            now_in = sat_inc(now_ff);
         end
         ST_FINISH: begin
            // Drop a negative wait to zero (only under tick saturation).
            fin_out_in = to_port(fin_ff);
            if ({1'b0, fin_ff} > used_ff) begin
               wait_out_in = to_port(wait_diff[TIME_BITS-1:0]);
            end else begin
               wait_out_in = '0;
            end
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= '0;
         now_ff      <= '0;
         cpu_busy_ff <= 1'b0;
         cur_ff      <= '0;
         rem_ff      <= '0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         now_ff      <= now_in;
         cpu_busy_ff <= cpu_busy_in;
         cur_ff      <= cur_in;
         rem_ff      <= rem_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      job_ff        <= job_in;
      burst_ff      <= burst_in;
      cnt_ff        <= cnt_in;
      pend_idx_ff   <= pend_idx_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      best_found_ff <= best_found_in;
      fin_ff        <= fin_in;
      used_ff       <= used_in;
      status_ff     <= status_in;
      run_id_ff     <= run_id_in;
      disp_ff       <= disp_in;
      done_ff       <= done_in;
      fin_out_ff    <= fin_out_in;
      wait_out_ff   <= wait_out_in;
   end

   // The latched op only steers the result code; keep it visible on status.
   assign busy            = state_ff != ST_IDLE;
   assign rsp_valid       = state_ff == ST_RESP;
   assign rsp_status      = (op_ff == OP_TICK) ? STATUS_TICK : status_ff;
   assign rsp_running_id  = run_id_ff;
   assign rsp_dispatched  = disp_ff;
   assign rsp_finished    = done_ff;
   assign rsp_finish_time = fin_out_ff;
   assign rsp_wait_time   = wait_out_ff;

endmodule

/* sv/nsjf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module nsjf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/nsjf_cmp.sv */
// Shared job-ordering comparator: least burst, then earliest arrival,
// then lowest job id. Depends on nsjf_pkg.
module nsjf_cmp
   import nsjf_pkg::*;
(
   input  slot_type cand,
   input  slot_type best,
   input  logic     best_found,
   output logic     better
);

   logic burst_lt, burst_eq, arr_lt, arr_eq, job_lt;

   assign burst_lt = cand.burst < best.burst;
   assign burst_eq = cand.burst == best.burst;
   assign arr_lt   = cand.arrival < best.arrival;
   assign arr_eq   = cand.arrival == best.arrival;
   assign job_lt   = cand.job < best.job;

   // Strict ordering: an equal candidate never displaces an earlier slot.
   assign better = !best_found || burst_lt || (burst_eq && arr_lt)
                   || (burst_eq && arr_eq && job_lt);

endmodule

/* sim/tb_top.sv */
// Self-checking bench for nonpreemptive_sjf_scheduler: directed rows, then random
// arrival/tick traffic in three idling phases.
// Depends on nsjf_pkg and the scheduler RTL only.
`timescale 1ns / 1ps

module tb_top
   import nsjf_pkg::*;
();

   // One result item as it leaves the rsp_ ports.
   typedef struct packed {
      logic [1:0]             status;
      logic [ID_BITS-1:0]     running_id;
      logic                   dispatched;
      logic                   finished;
      logic [PORT_TIME_W-1:0] finish_time;
      logic [PORT_TIME_W-1:0] wait_time;
   } sched_result_type;

   // One row of the directed plan; want is used only when typed is set.
   typedef struct {
      logic               op;
      logic [ID_BITS-1:0] job_id;
      logic [BURST_W-1:0] burst;
      bit                 typed;
      sched_result_type   want;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   req_op = OP_ARRIVE;
   logic [ID_BITS-1:0]     req_job_id = '0;
   logic [BURST_W-1:0]     req_burst = '0;
   logic                   busy;
   logic                   rsp_valid;
   logic [1:0]             rsp_status;
   logic [ID_BITS-1:0]     rsp_running_id;
   logic                   rsp_dispatched;
   logic                   rsp_finished;
   logic [PORT_TIME_W-1:0] rsp_finish_time;
   logic [PORT_TIME_W-1:0] rsp_wait_time;

   sched_result_type pending_results[$];
   plan_row_type     plan[$];
   int               error_count = 0;

   // Scheduler state as the bench sees it: ready table, tick counter, CPU.
   bit                   tbl_valid[TABLE_DEPTH];
   logic [ID_BITS-1:0]   tbl_job[TABLE_DEPTH];
   logic [TIME_BITS-1:0] tbl_arrival[TABLE_DEPTH];
   logic [TIME_BITS-1:0] tbl_burst[TABLE_DEPTH];
   logic [TIME_BITS-1:0] sched_now = '0;
   bit                   cpu_running = 1'b0;
   logic [ID_BITS-1:0]   cpu_job = '0;
   logic [TIME_BITS-1:0] cpu_arrival = '0;
   logic [TIME_BITS-1:0] cpu_burst = '0;
   logic [TIME_BITS-1:0] cpu_left = '0;

   nonpreemptive_sjf_scheduler dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_job_id      (req_job_id),
      .req_burst       (req_burst),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_running_id  (rsp_running_id),
      .rsp_dispatched  (rsp_dispatched),
      .rsp_finished    (rsp_finished),
      .rsp_finish_time (rsp_finish_time),
      .rsp_wait_time   (rsp_wait_time)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop in case a result never shows up or busy never drops.
   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

   // Count occupied slots of the ready table.
   function automatic int table_used();
      int cnt;
      cnt = 0;
      foreach (tbl_valid[i]) if (tbl_valid[i]) cnt++;
      return cnt;
   endfunction

   // Advance the bench copy of the scheduler by one item and return its result.
   function automatic sched_result_type sjf_predict(input logic op,
                                                    input logic [ID_BITS-1:0] job_id,
                                                    input logic [BURST_W-1:0] burst);
      sched_result_type     r;
      int                   slot;
      logic [TIME_BITS-1:0] fin;
      logic [TIME_BITS:0]   used;
      r = '0;
      if (op == OP_ARRIVE) begin
         // A zero burst is refused before the table is even looked at.
         if (burst == '0) begin
            r.status = STATUS_ZERO_BURST;
            return r;
         end
         slot = -1;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!tbl_valid[i]) begin
               slot = i;
               break;
            end
         end
         if (slot < 0) begin
            r.status = STATUS_FULL;
            return r;
         end
         tbl_valid[slot]   = 1'b1;
         tbl_job[slot]     = job_id;
         tbl_arrival[slot] = sched_now;
         tbl_burst[slot]   = (32'(burst) > 32'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(burst);
         r.status = STATUS_ACCEPTED;
         return r;
      end

      r.status = STATUS_TICK;
      if (!cpu_running) begin
         // Least burst, then earliest arrival, then lowest id; equal rows keep
         // the lower slot because the compare is strict.
         slot = -1;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_valid[i] && (slot < 0 || tbl_burst[i] < tbl_burst[slot] ||
                (tbl_burst[i] == tbl_burst[slot] &&
                 (tbl_arrival[i] < tbl_arrival[slot] ||
                  (tbl_arrival[i] == tbl_arrival[slot] && tbl_job[i] < tbl_job[slot])))))
               slot = i;
         end
         if (slot >= 0) begin
            tbl_valid[slot] = 1'b0;
            cpu_job      = tbl_job[slot];
            cpu_arrival  = tbl_arrival[slot];
            cpu_burst    = tbl_burst[slot];
            cpu_left     = tbl_burst[slot];
            cpu_running  = 1'b1;
            r.dispatched = 1'b1;
         end
      end
      if (cpu_running) begin
         if (cpu_left != '0) cpu_left--;
         r.running_id = cpu_job;
         if (cpu_left == '0) begin
            fin  = (sched_now == TIME_MAX) ? sched_now : sched_now + 1'b1;
            used = {1'b0, cpu_arrival} + {1'b0, cpu_burst};
            r.finished    = 1'b1;
            r.finish_time = PORT_TIME_W'(fin);
            // Clamp at zero once saturation pulls the finish below arrival plus burst.
            r.wait_time   = ({1'b0, fin} > used) ? PORT_TIME_W'({1'b0, fin} - used) : '0;
            cpu_running   = 1'b0;
         end
      end
      if (sched_now != TIME_MAX) sched_now++;
      return r;
   endfunction

   function automatic void add_row(input logic op, input logic [ID_BITS-1:0] job_id,
                                   input logic [BURST_W-1:0] burst, input bit typed = 1'b0,
                                   input logic [1:0] status = STATUS_ACCEPTED,
                                   input logic [ID_BITS-1:0] running_id = '0,
                                   input logic dispatched = 1'b0, input logic finished = 1'b0,
                                   input logic [PORT_TIME_W-1:0] finish_time = '0,
                                   input logic [PORT_TIME_W-1:0] wait_time = '0);
      plan_row_type row;
      row.op     = op;
      row.job_id = job_id;
      row.burst  = burst;
      row.typed  = typed;
      row.want   = '{status, running_id, dispatched, finished, finish_time, wait_time};
      plan = {plan, row};
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      // Keep the log readable if the block is badly broken.
      if (error_count <= 50)
         $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
   endtask

   // Present an item at the falling edge and hold it until an edge sees busy low.
   task automatic send_item(input logic op, input logic [ID_BITS-1:0] job_id,
                            input logic [BURST_W-1:0] burst, input bit typed = 1'b0,
                            input sched_result_type typed_want = '0);
      sched_result_type predicted;
      @(negedge clock);
      req_op     <= op;
      req_job_id <= job_id;
      req_burst  <= burst;
      start      <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predicted = sjf_predict(op, job_id, burst);
      pending_results = {pending_results, (typed ? typed_want : predicted)};
   endtask

   task automatic idle_cycle();
      @(negedge clock);
      start <= 1'b0;
   endtask

   // Drop start and hold off until every outstanding result is back.
   task automatic drain_results();
      idle_cycle();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_tick();
      send_item(OP_TICK, ID_BITS'($urandom), BURST_W'($urandom));
   endtask

   // Result checker: every strobe must match the oldest expectation, field by field.
   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending, status", 32'(rsp_status), '1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_valid !== 1'b1)
               report_mismatch("rsp_valid", 32'(rsp_valid), 32'(1'b1));
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_running_id !== want.running_id)
               report_mismatch("running_id", 32'(rsp_running_id), 32'(want.running_id));
            if (rsp_dispatched !== want.dispatched)
               report_mismatch("dispatched", 32'(rsp_dispatched), 32'(want.dispatched));
            if (rsp_finished !== want.finished)
               report_mismatch("finished", 32'(rsp_finished), 32'(want.finished));
            if (rsp_finish_time !== want.finish_time)
               report_mismatch("finish_time", 32'(rsp_finish_time), 32'(want.finish_time));
            if (rsp_wait_time !== want.wait_time)
               report_mismatch("wait_time", 32'(rsp_wait_time), 32'(want.wait_time));
         end
      end
   end

   initial begin
      int                 gap_pct[3];
      int                 arr_pct;
      int                 pick;
      logic               op;
      logic [ID_BITS-1:0] job_id;
      logic [BURST_W-1:0] burst;

      gap_pct = '{25, 88, 0};
      arr_pct = 50;
      foreach (tbl_valid[i]) begin
         tbl_valid[i]   = 1'b0;
         tbl_job[i]     = '0;
         tbl_arrival[i] = '0;
         tbl_burst[i]   = '0;
      end

      // Directed plan. Rows with typed results can be checked by eye.
      // Idle CPU with an empty table: nothing runs.
      add_row(OP_TICK, 8'h00, 16'h0000, 1'b1, STATUS_TICK, 8'h00, 1'b0, 1'b0, 16'd0, 16'd0);
      add_row(OP_ARRIVE, 8'hff, 16'h0000, 1'b1, STATUS_ZERO_BURST);
      // Job id zero is legal; ties on burst and arrival fall to the lower id.
      add_row(OP_ARRIVE, 8'h00, 16'h0002, 1'b1, STATUS_ACCEPTED);
      add_row(OP_ARRIVE, 8'h05, 16'h0002);
      add_row(OP_ARRIVE, 8'h03, 16'h0001);
      add_row(OP_TICK, 8'hff, 16'hffff, 1'b1, STATUS_TICK, 8'h03, 1'b1, 1'b1, 16'd2, 16'd0);
      add_row(OP_TICK, 8'h00, 16'h0000, 1'b1, STATUS_TICK, 8'h00, 1'b1, 1'b0, 16'd0, 16'd0);
      add_row(OP_TICK, 8'h00, 16'h0000, 1'b1, STATUS_TICK, 8'h00, 1'b0, 1'b1, 16'd4, 16'd1);
      // Fill the remaining fifteen slots; the lower id in a higher slot must win.
      add_row(OP_ARRIVE, 8'h80, 16'h0001);
      add_row(OP_ARRIVE, 8'h40, 16'h0001);
      add_row(OP_ARRIVE, 8'h01, 16'h0003);
      add_row(OP_ARRIVE, 8'h02, 16'h0004);
      add_row(OP_ARRIVE, 8'h04, 16'h0002);
      add_row(OP_ARRIVE, 8'h08, 16'h0005);
      add_row(OP_ARRIVE, 8'h10, 16'h0009);
      add_row(OP_ARRIVE, 8'h20, 16'h0006);
      add_row(OP_ARRIVE, 8'haa, 16'h0007);
      add_row(OP_ARRIVE, 8'h55, 16'h0008);
      add_row(OP_ARRIVE, 8'h7f, 16'h0002);
      add_row(OP_ARRIVE, 8'hfe, 16'h0003);
      add_row(OP_ARRIVE, 8'hc0, 16'h0004);
      add_row(OP_ARRIVE, 8'h0c, 16'h0001);
      add_row(OP_ARRIVE, 8'h33, 16'h0005);
      // Full table, and a zero burst that must be refused as such even when full.
      add_row(OP_ARRIVE, 8'h99, 16'hffff, 1'b1, STATUS_FULL);
      add_row(OP_ARRIVE, 8'h66, 16'h0000, 1'b1, STATUS_ZERO_BURST);
      add_row(OP_TICK, 8'h5a, 16'ha5a5);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         while ($urandom_range(99) < 25) idle_cycle();
         send_item(plan[i].op, plan[i].job_id, plan[i].burst, plan[i].typed, plan[i].want);
      end
      drain_results();

      // Random traffic in three idling phases. The arrival share moves in blocks
      // so the table alternately fills up, churns and runs dry.
      for (int ph = 0; ph < 3; ph++) begin
         for (int n = 0; n < 550; n++) begin
            if (n % 40 == 0) arr_pct = 25 * (1 + $urandom_range(2));
            if ($urandom_range(59) == 0) drain_results();
            while ($urandom_range(99) < gap_pct[ph]) idle_cycle();
            op     = ($urandom_range(99) < arr_pct) ? OP_ARRIVE : OP_TICK;
            job_id = ID_BITS'($urandom);
            pick   = $urandom_range(99);
            if (op == OP_TICK || table_used() == TABLE_DEPTH)
               burst = BURST_W'($urandom);        // ignored or refused: any value
            else if (pick < 4)
               burst = '0;
            else if (pick < 80)
               burst = BURST_W'($urandom_range(1, 6));
            else if (pick < 96)
               burst = BURST_W'($urandom_range(7, 24));
            else
               burst = BURST_W'($urandom_range(25, 120));
            send_item(op, job_id, burst);
         end
         drain_results();
      end

      drain_results();
      repeat (30) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
